// File: design/lfmc_pkg.sv
// shared types, constants and helpers for the line follow motor controller
package lfmc_pkg;

   localparam int RATIO_W = 10;
   localparam int BASE_W  = 15;
   localparam int STOP_W  = 16;
   localparam int TIME_W  = 32;
   localparam int DIST_W  = 32;
   localparam int CMP_W   = 16;
   localparam int PROD_W  = BASE_W + RATIO_W;

   localparam logic [RATIO_W-1:0] RATIO_MID  = RATIO_W'(500);
   localparam logic [RATIO_W-1:0] RATIO_MIN  = RATIO_W'(350);
   localparam logic [RATIO_W-1:0] RATIO_MAX  = RATIO_W'(650);
   localparam logic [RATIO_W:0]   RATIO_FULL = (RATIO_W + 1)'(1000);

   localparam logic [7:0] DIST_PER_MS = 8'd170;

   localparam logic [BASE_W-1:0] BASE_SPEED_RESET    = BASE_W'(1250);
   localparam logic [STOP_W-1:0] STOP_DISTANCE_RESET = STOP_W'(10);

   // divide by 500 as a shift by 2 then an exact reciprocal multiply for 125
   localparam int          RECIP_SHIFT = 30;
   localparam logic [23:0] RECIP_125   = 24'd8589935;

   typedef logic [RATIO_W-1:0] ratio_type;

   typedef enum logic [0:0] {
      CSR_BASE_SPEED    = 1'b0,
      CSR_STOP_DISTANCE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              centre_left_on;
      logic              centre_right_on;
      logic              echo_level;
      logic [TIME_W-1:0] now_ms;
   } sample_type;

   typedef struct packed {
      logic      motor_enable;
      ratio_type ratio;
   } sense_type;

   function automatic logic [CMP_W-1:0] div_by_500(input logic [PROD_W-1:0] value);
      logic [PROD_W-3:0]     quarter;
      logic [PROD_W+21:0]    scaled;
      quarter = value[PROD_W-1:2];
      scaled  = (PROD_W + 22)'(quarter) * (PROD_W + 22)'(RECIP_125);
      return scaled[RECIP_SHIFT +: CMP_W];
   endfunction

endpackage

// File: design/lfmc_if.sv
// valid/ready channel interfaces for sample, result and register write beats
interface lfmc_req_if;
   logic        valid;
   logic        ready;
   logic        centre_left_on;
   logic        centre_right_on;
   logic        echo_level;
   logic [31:0] now_ms;

   modport source (output valid, centre_left_on, centre_right_on, echo_level, now_ms,
                   input ready);
   modport sink   (input valid, centre_left_on, centre_right_on, echo_level, now_ms,
                   output ready);
endinterface

interface lfmc_rsp_if;
   logic        valid;
   logic        ready;
   logic        motor_enable;
   logic [15:0] right_compare;
   logic [15:0] left_compare;
   logic [9:0]  ratio_now;

   modport source (output valid, motor_enable, right_compare, left_compare, ratio_now,
                   input ready);
   modport sink   (input valid, motor_enable, right_compare, left_compare, ratio_now,
                   output ready);
endinterface

interface lfmc_csr_if;
   logic                        valid;
   logic                        ready;
   lfmc_pkg::csr_index_type     index;
   logic [15:0]                 data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/lfmc_sense.sv
// steering ratio and echo timing state, updated once per committed sample
module lfmc_sense (
   input  logic                             clock,
   input  logic                             reset,
   input  lfmc_pkg::sample_type             sample,
   input  logic                             commit,
   input  logic [lfmc_pkg::STOP_W-1:0]      stop_distance,
   output lfmc_pkg::sense_type              sense
);
   import lfmc_pkg::*;

   ratio_type          ratio_ff, ratio_in;
   logic               echo_prev_ff;
   logic [TIME_W-1:0]  echo_start_ff, echo_start_in;
   logic [DIST_W-1:0]  distance_ff, distance_in;
   logic               line_seen;
   logic [TIME_W-1:0]  duration;
   logic [TIME_W+7:0]  dist_full;

   always_comb begin
      line_seen = 1'b1;
      ratio_in  = ratio_ff;
      unique case ({sample.centre_left_on, sample.centre_right_on})
         2'b11: ratio_in = RATIO_MID;
         2'b00: begin
            ratio_in  = RATIO_MID;
            line_seen = 1'b0;
         end
         2'b10: begin
            if (ratio_ff > RATIO_MIN) ratio_in = ratio_ff - RATIO_W'(1);
         end
         2'b01: begin
            if (ratio_ff < RATIO_MAX) ratio_in = ratio_ff + RATIO_W'(1);
         end
      endcase
   end

   // echo pulse width to distance, saturating
   always_comb begin
      duration      = sample.now_ms - echo_start_ff;
      dist_full     = (TIME_W + 8)'(duration) * (TIME_W + 8)'(DIST_PER_MS);
      echo_start_in = echo_start_ff;
      distance_in   = distance_ff;
      if (sample.echo_level && !echo_prev_ff) echo_start_in = sample.now_ms;
      if (!sample.echo_level && echo_prev_ff) begin
         distance_in = (|dist_full[TIME_W+7:TIME_W]) ? '1 : dist_full[DIST_W-1:0];
      end
   end

   assign sense.motor_enable = line_seen && (distance_in >= DIST_W'(stop_distance));
   assign sense.ratio        = ratio_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff      <= RATIO_MID;
         echo_prev_ff  <= 1'b0;
         echo_start_ff <= '0;
         distance_ff   <= '0;
      end else if (commit) begin
         ratio_ff      <= ratio_in;
         echo_prev_ff  <= sample.echo_level;
         echo_start_ff <= echo_start_in;
         distance_ff   <= distance_in;
      end
   end

endmodule

// File: design/line_follow_motor_controller_core.sv
// top level: sample register, steering state, compare scaling and result register
// a sample beat goes through sample_ff, en2_ff/ratio2_ff, prod_r3_ff/prod_l3_ff and the result register
// throughput: one sample beat per cycle; the four stages stall together only when
// rsp backpressure fills them, ready follows the stage chain from rsp_bus.ready
// reset: clears all stage valids, sets ratio to straight, echo timing and distance
// to zero, base_speed to 1250 and stop_distance to 10
module line_follow_motor_controller_core (
   input  logic         clock,
   input  logic         reset,
   lfmc_req_if.sink     req_bus,
   lfmc_rsp_if.source   rsp_bus,
   lfmc_csr_if.sink     csr_bus
);
   import lfmc_pkg::*;

   logic [BASE_W-1:0]  base_speed_ff;
   logic [STOP_W-1:0]  stop_distance_ff;

   logic               v1_ff, v2_ff, v3_ff, rsp_v_ff;
   logic               s1_free, s2_free, s3_free, s4_free;

   sample_type         sample_ff, sample_in;
   sense_type          sense;

   logic               en2_ff;
   ratio_type          ratio2_ff;

   logic               en3_ff;
   ratio_type          ratio3_ff;
   logic [PROD_W-1:0]  prod_r3_ff, prod_r3_in;
   logic [PROD_W-1:0]  prod_l3_ff, prod_l3_in;

   logic               enable_ff;
   logic [CMP_W-1:0]   right_ff, right_in;
   logic [CMP_W-1:0]   left_ff, left_in;
   ratio_type          ratio_out_ff;

   // stage handshakes
   assign s4_free = !rsp_v_ff || rsp_bus.ready;
   assign s3_free = !v3_ff || s4_free;
   assign s2_free = !v2_ff || s3_free;
   assign s1_free = !v1_ff || s2_free;
   assign req_bus.ready = s1_free;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_free) v1_ff    <= req_bus.valid;
         if (s2_free) v2_ff    <= v1_ff;
         if (s3_free) v3_ff    <= v2_ff;
         if (s4_free) rsp_v_ff <= v3_ff;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_speed_ff    <= BASE_SPEED_RESET;
         stop_distance_ff <= STOP_DISTANCE_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_BASE_SPEED:    base_speed_ff    <= csr_bus.data[BASE_W-1:0];
            CSR_STOP_DISTANCE: stop_distance_ff <= csr_bus.data[STOP_W-1:0];
         endcase
      end
   end

   // stage 1: sample register and state update
   always_comb begin
      sample_in.centre_left_on  = req_bus.centre_left_on;
      sample_in.centre_right_on = req_bus.centre_right_on;
      sample_in.echo_level      = req_bus.echo_level;
      sample_in.now_ms          = req_bus.now_ms;
   end

   always_ff @(posedge clock) begin
      if (s1_free) sample_ff <= sample_in;
   end

   lfmc_sense u_sense (
      .clock         (clock),
      .reset         (reset),
      .sample        (sample_ff),
      .commit        (v1_ff && s2_free),
      .stop_distance (stop_distance_ff),
      .sense         (sense)
   );

   always_ff @(posedge clock) begin
      if (s2_free) begin
         en2_ff    <= sense.motor_enable;
         ratio2_ff <= sense.ratio;
      end
   end

   // stage 2: compare products, zero when disabled
   always_comb begin
      prod_r3_in = '0;
      prod_l3_in = '0;
      if (en2_ff) begin
         prod_r3_in = PROD_W'(base_speed_ff) * PROD_W'(RATIO_FULL - (RATIO_W + 1)'(ratio2_ff));
         prod_l3_in = PROD_W'(base_speed_ff) * PROD_W'(ratio2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_free) begin
         en3_ff     <= en2_ff;
         ratio3_ff  <= ratio2_ff;
         prod_r3_ff <= prod_r3_in;
         prod_l3_ff <= prod_l3_in;
      end
   end

   // stage 3: scale by 1/500 into the result register
   assign right_in = div_by_500(prod_r3_ff);
   assign left_in  = div_by_500(prod_l3_ff);

   always_ff @(posedge clock) begin
      if (s4_free) begin
         enable_ff    <= en3_ff;
         right_ff     <= right_in;
         left_ff      <= left_in;
         ratio_out_ff <= ratio3_ff;
      end
   end

   assign rsp_bus.valid         = rsp_v_ff;
   assign rsp_bus.motor_enable  = enable_ff;
   assign rsp_bus.right_compare = right_ff;
   assign rsp_bus.left_compare  = left_ff;
   assign rsp_bus.ratio_now     = ratio_out_ff;

endmodule
